/* rtl/salru_pkg.sv */
package salru_pkg;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_LOOK  = 3'b100
   } state_type;

endpackage

/* rtl/salru_set_ram.sv */
module salru_set_ram
   import salru_pkg::*;
#(
   parameter int DEPTH = 8,
   parameter int WIDTH = 100,
   parameter int AW    = 3
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/salru_way_logic.sv */
module salru_way_logic
   import salru_pkg::*;
#(
   parameter int WAY_COUNT = 4,
   parameter int TAG_W     = 23,
   parameter int RANK_W    = 2
) (
   input  logic [WAY_COUNT-1:0][TAG_W-1:0]  row_tags,
   input  logic [WAY_COUNT-1:0][RANK_W-1:0] row_ranks,
   input  logic [WAY_COUNT-1:0]             row_valid,
   input  logic [TAG_W-1:0]                 req_tag,
   output logic                             hit,
   output logic [WAY_COUNT-1:0][TAG_W-1:0]  new_tags,
   output logic [WAY_COUNT-1:0][RANK_W-1:0] new_ranks,
   output logic [WAY_COUNT-1:0]             new_valid
);

   localparam int WAY_IW = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

   logic              hit_found;
   logic              free_found;
   logic [WAY_IW-1:0] hit_way;
   logic [WAY_IW-1:0] free_way;
   logic [WAY_IW-1:0] vic_way;
   logic [WAY_IW-1:0] slot;
   logic [RANK_W-1:0] best;
   logic [RANK_W-1:0] slot_rank;

   always_comb begin
      hit_found  = 1'b0;
      free_found = 1'b0;
      hit_way    = '0;
      free_way   = '0;
      vic_way    = '0;
      best       = '0;
      for (int w = 0; w < WAY_COUNT; w++) begin
         if (!hit_found && row_valid[w] && row_tags[w] == req_tag) begin
            hit_found = 1'b1;
            hit_way   = WAY_IW'(w);
         end
         if (!free_found && !row_valid[w]) begin
            free_found = 1'b1;
            free_way   = WAY_IW'(w);
         end
         if (row_ranks[w] > best) begin
            best    = row_ranks[w];
            vic_way = WAY_IW'(w);
         end
      end
   end

   assign hit       = hit_found;
   assign slot      = hit_found ? hit_way : (free_found ? free_way : vic_way);
   assign slot_rank = row_ranks[slot];

   // hit: age ways more recent than the hit way; miss: age every other valid way
   always_comb begin
      new_tags  = row_tags;
      new_ranks = row_ranks;
      new_valid = row_valid;
      for (int w = 0; w < WAY_COUNT; w++) begin
         if (WAY_IW'(w) != slot && row_valid[w]
               && (!hit_found || row_ranks[w] < slot_rank)) begin
            new_ranks[w] = row_ranks[w] + RANK_W'(1);
         end
      end
      new_ranks[slot] = '0;
      new_valid[slot] = 1'b1;
      new_tags[slot]  = req_tag;
   end

endmodule

/* rtl/set_assoc_lru_cache_miss_counter.sv */
// Channel  Dir  Beat content
// req      in   tdata[31:0] byte_address
// rsp      out  tdata[0] hit, [32:1] access_total, [64:33] miss_total, [71:65] zero
//
// One access reads the set row from the RAM, then does the tag compare, LRU update
// and row write-back; the single-port-per-direction set RAM sets this split.
// After reset a clearing pass zeroes every row of the set RAM; no req beat is
// taken until it ends. The rsp register frees req: a new access is taken while a
// result waits, and a second result stalls only the update cycle.
module set_assoc_lru_cache_miss_counter
   import salru_pkg::*;
#(
   parameter int BLOCK_BYTES = 64,
   parameter int SET_COUNT   = 8,
   parameter int WAY_COUNT   = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // byte_address
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // hit, access_total, miss_total, zero pad
);

   localparam longint ADDR_SPAN = 64'h1_0000_0000;
   localparam int TAG_W  = $clog2(ADDR_SPAN / (BLOCK_BYTES * SET_COUNT));
   localparam int SET_AW = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
   localparam int RANK_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
   localparam int ROW_W  = WAY_COUNT * (TAG_W + RANK_W + 1);

   state_type   state_ff, state_in;
   logic [SET_AW-1:0] clr_ff, clr_in;
   logic [SET_AW-1:0] set_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [31:0] access_ff, access_in;
   logic [31:0] miss_ff, miss_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_hit_ff;
   logic [31:0] rsp_access_ff;
   logic [31:0] rsp_miss_ff;

   logic [31:0]       line_num;
   logic [SET_AW-1:0] req_set;
   logic [TAG_W-1:0]  req_tag;
   logic              accept;
   logic              commit;
   logic              rd_en;
   logic              wr_en;
   logic [SET_AW-1:0] wr_addr;
   logic [ROW_W-1:0]  wr_data;
   logic [ROW_W-1:0]  rd_row;

   logic [WAY_COUNT-1:0][TAG_W-1:0]  row_tags, new_tags;
   logic [WAY_COUNT-1:0][RANK_W-1:0] row_ranks, new_ranks;
   logic [WAY_COUNT-1:0]             row_valid, new_valid;
   logic                             hit;

   assign line_num = req_tdata / BLOCK_BYTES;
   assign req_set  = SET_AW'(line_num % SET_COUNT);
   assign req_tag  = TAG_W'(line_num / SET_COUNT);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign commit     = (state_ff == ST_LOOK) && (!rsp_valid_ff || rsp_tready);
   assign rd_en      = accept;

   assign {row_valid, row_ranks, row_tags} = rd_row;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = set_ff;
      wr_data = {new_valid, new_ranks, new_tags};
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (commit) begin
         wr_en = 1'b1;
      end
   end

   salru_set_ram #(
      .DEPTH (SET_COUNT),
      .WIDTH (ROW_W),
      .AW    (SET_AW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (req_set),
      .rd_data (rd_row),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   salru_way_logic #(
      .WAY_COUNT (WAY_COUNT),
      .TAG_W     (TAG_W),
      .RANK_W    (RANK_W)
   ) u_ways (
      .row_tags  (row_tags),
      .row_ranks (row_ranks),
      .row_valid (row_valid),
      .req_tag   (tag_ff),
      .hit       (hit),
      .new_tags  (new_tags),
      .new_ranks (new_ranks),
      .new_valid (new_valid)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      access_in    = access_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SET_AW'(1);
            if (clr_ff == SET_AW'(SET_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               access_in    = (access_ff == COUNT_MAX) ? access_ff : access_ff + 32'd1;
               if (!hit) begin
                  miss_in = (miss_ff == COUNT_MAX) ? miss_ff : miss_ff + 32'd1;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         access_ff    <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         access_ff    <= access_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff <= req_set;
         tag_ff <= req_tag;
      end
      if (commit) begin
         rsp_hit_ff    <= hit;
         rsp_access_ff <= access_in;
         rsp_miss_ff   <= miss_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_miss_ff, rsp_access_ff, rsp_hit_ff};

endmodule

/* verif/set_assoc_lru_cache_miss_counter_test.sv */
`timescale 1ns / 1ps

module set_assoc_lru_cache_miss_counter_test;
   import salru_pkg::*;

   localparam int BLOCK_BYTES  = 64;
   localparam int SET_COUNT    = 8;
   localparam int WAY_COUNT    = 4;
   localparam int STALL_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 10;

   typedef struct packed {
      logic        hit;
      logic [31:0] access_total;
      logic [31:0] miss_total;
   } lookup_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // byte_address
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // hit, access_total, miss_total, zero pad

   // cache image
   logic [22:0] way_tag   [SET_COUNT][WAY_COUNT];
   bit          way_valid [SET_COUNT][WAY_COUNT];
   logic [1:0]  way_rank  [SET_COUNT][WAY_COUNT];
   logic [31:0] access_count = '0;
   logic [31:0] misses_seen  = '0;

   lookup_result_type expected_lookups[$];
   logic [22:0]       tag_pool[6];

   int error_count       = 0;
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int hold_off_left     = 0;
   int quiet_cycles      = 0;

   set_assoc_lru_cache_miss_counter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ages valid ways below limit, then makes slot most recent
   function automatic void make_most_recent(input int set_idx, input int slot, input int limit);
      for (int w = 0; w < WAY_COUNT; w++) begin
         if (w != slot && way_valid[set_idx][w] && int'(way_rank[set_idx][w]) < limit) begin
            way_rank[set_idx][w] = way_rank[set_idx][w] + 2'd1;
         end
      end
      way_rank[set_idx][slot] = 2'd0;
   endfunction

   function automatic lookup_result_type lookup_line(input logic [31:0] addr);
      int                set_idx;
      logic [22:0]       tag;
      int                slot;
      int                best;
      bit                found;
      bit                hit_seen;
      lookup_result_type res;
      set_idx = int'(addr[8:6]);
      tag     = addr[31:9];
      slot    = 0;
      found   = 1'b0;
      if (access_count != COUNT_MAX) access_count = access_count + 32'd1;
      for (int w = 0; w < WAY_COUNT; w++) begin
         if (!found && way_valid[set_idx][w] && way_tag[set_idx][w] == tag) begin
            found = 1'b1;
            slot  = w;
         end
      end
      hit_seen = found;
      if (found) begin
         make_most_recent(set_idx, slot, int'(way_rank[set_idx][slot]));
      end else begin
         if (misses_seen != COUNT_MAX) misses_seen = misses_seen + 32'd1;
         for (int w = WAY_COUNT - 1; w >= 0; w--) begin
            if (!way_valid[set_idx][w]) begin
               found = 1'b1;
               slot  = w;
            end
         end
         if (!found) begin
            // victim: highest rank, ties to lowest way
            best = 0;
            slot = 0;
            for (int w = 0; w < WAY_COUNT; w++) begin
               if (int'(way_rank[set_idx][w]) > best) begin
                  best = int'(way_rank[set_idx][w]);
                  slot = w;
               end
            end
         end
         way_valid[set_idx][slot] = 1'b0;
         make_most_recent(set_idx, slot, WAY_COUNT);
         way_tag[set_idx][slot]   = tag;
         way_valid[set_idx][slot] = 1'b1;
      end
      res.hit          = hit_seen;
      res.access_total = access_count;
      res.miss_total   = misses_seen;
      return res;
   endfunction

   function automatic logic [31:0] line_address(input int set_idx, input logic [22:0] tag);
      return {tag, 3'(set_idx), 6'd0};
   endfunction

   function automatic logic [31:0] pick_address();
      if ($urandom_range(0, 99) < 15) return $urandom;
      return {tag_pool[$urandom_range(0, 5)], 3'($urandom_range(0, SET_COUNT - 1)),
              6'($urandom_range(0, BLOCK_BYTES - 1))};
   endfunction

   task automatic flag_error(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t ns: %s: got %h, want %h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic send_access(input logic [31:0] addr);
      lookup_result_type res;
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = addr;
      do @(posedge clock); while (!req_tready);
      res = lookup_line(addr);
      expected_lookups.push_back(res);
   endtask

   // rsp side: random stalls, or a forced hold-off
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready = 1'b0;
         hold_off_left--;
      end else begin
         rsp_tready = ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_lookups.size() == 0) begin
            flag_error("result beat with no pending access", rsp_tdata[32:1], '0);
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_tdata[0] !== want.hit)
               flag_error("hit", 32'(rsp_tdata[0]), 32'(want.hit));
            if (rsp_tdata[32:1] !== want.access_total)
               flag_error("access_total", rsp_tdata[32:1], want.access_total);
            if (rsp_tdata[64:33] !== want.miss_total)
               flag_error("miss_total", rsp_tdata[64:33], want.miss_total);
            if (rsp_tdata[71:65] !== 7'd0)
               flag_error("pad bits", 32'(rsp_tdata[71:65]), '0);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic test_directed_corners();
      send_access(32'h0000_0000);
      send_access(32'h0000_003F);
      send_access(32'hFFFF_FFFF);
      send_access(32'hFFFF_FFC0);
      // fill set 0, then hit a middle rank and evict in LRU order
      send_access(line_address(0, 23'd1));
      send_access(line_address(0, 23'd2));
      send_access(line_address(0, 23'd3));
      send_access(line_address(0, 23'd1));
      send_access(line_address(0, 23'd4));
      send_access(line_address(0, 23'd0));
      send_access(line_address(0, 23'd2));
      send_access(line_address(0, 23'd1));
      send_access(line_address(0, 23'd4));
      send_access(line_address(0, 23'd3));
      send_access(line_address(0, 23'd0));
      send_access(32'hAAAA_AAAA);
      send_access(32'h5555_5555);
      send_access(32'hAAAA_AAAB);
      send_access(32'h5555_5540);
   endtask

   task automatic test_random_traffic(input int count, input int tx_idle, input int rx_idle);
      sender_idle_pct   = tx_idle;
      receiver_idle_pct = rx_idle;
      tag_pool[0] = 23'h00_0000;
      tag_pool[1] = 23'h7F_FFFF;
      for (int i = 2; i < 6; i++) tag_pool[i] = 23'($urandom);
      for (int i = 0; i < count; i++) send_access(pick_address());
   endtask

   task automatic test_rsp_hold_off();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      hold_off_left     = 300;
      for (int i = 0; i < 60; i++) send_access(pick_address());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_corners();
      test_random_traffic(560, 14, 78);
      test_random_traffic(560, 78, 14);
      test_random_traffic(560, 0, 0);
      test_rsp_hold_off();

      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_lookups.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
